/* rtl/skht_pkg.sv */
// Shared constants and codes for the string key hash table.
package skht_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int KEY_BYTES     = 64;
  localparam int KIDX_W        = $clog2(KEY_BYTES);
  localparam int LEN_W         = 7;
  localparam int CNT_W         = 9;
  localparam int HASH_W        = 64;
  localparam int VAL_W         = 32;

  // Request actions.
  localparam logic [1:0] ACT_GET    = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_TOOLONG  = 2'd3;

endpackage

/* rtl/skht_keybuf.sv */
// Key buffer: collects key bytes, forms the running hash and serves byte reads.
module skht_keybuf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [7:0]                  key_byte,
  input  logic                        byte_present,
  input  logic                        clear,
  input  logic [skht_pkg::KIDX_W-1:0] rd_idx,
  output logic [skht_pkg::HASH_W-1:0] hash,
  output logic [skht_pkg::LEN_W-1:0]  len,
  output logic                        overlong,
  output logic [7:0]                  rd_data
);
  import skht_pkg::*;

  logic [7:0] key_mem [KEY_BYTES];
  logic       add;
  logic       full;

  assign add  = take && byte_present && (key_byte != 8'd0);
  assign full = (len >= LEN_W'(KEY_BYTES));

  // Hash, length and overflow flag of the request in progress.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hash     <= '0;
      len      <= '0;
      overlong <= 1'b0;
    end else if (add) begin
      if (full) begin
        overlong <= 1'b1;
      end else begin
        hash <= (hash << 7) + (hash << 1) + hash + HASH_W'(key_byte);
        len  <= len + LEN_W'(1);
      end
    end
  end

  // Byte store with a registered read port.
  always_ff @(posedge clk) begin
    if (add && !full) begin
      key_mem[len[KIDX_W-1:0]] <= key_byte;
    end
    rd_data <= key_mem[rd_idx];
  end

endmodule

/* rtl/string_key_hash_table.sv */
// Top level of the string key hash table with linear probing.
//
// Usage: a request sends its key one byte per input item on the in_* channel
// (valid/stall); action and new_value are taken from the item with last set.
// An empty key is a single item with byte_present low. Items before the last
// one are taken one per cycle. The last item starts the operation and the
// input stalls until its result is loaded into the output register.
// The operation probes the occupied slots from the home slot and compares the
// key bytes one at a time; a set of a new key then searches for a free slot and
// copies the key byte by byte, and a remove walks over the following cluster
// with a free-slot search and a key copy per moved entry. The slot memories
// have a single port and the key memory port reads one byte at a time.
// The output register holds one result; it stays stable while out_stall is
// high, and key bytes of the next request are accepted meanwhile.
// Reset clears the occupancy bits, the entry count and the key buffer at once;
// no clearing pass is needed. Clear action resets the occupancy bits and count.
module string_key_hash_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  key_byte,
  input  logic        byte_present,
  input  logic        last,
  input  logic signed [31:0] new_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        found,
  output logic signed [31:0] read_value,
  output logic [8:0]  entry_count
);
  import skht_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_PROBE = 4'd2;
  localparam logic [3:0] S_MATCH = 4'd3;
  localparam logic [3:0] S_CRD   = 4'd4;
  localparam logic [3:0] S_CCK   = 4'd5;
  localparam logic [3:0] S_ACT   = 4'd6;
  localparam logic [3:0] S_FREE  = 4'd7;
  localparam logic [3:0] S_CPRD  = 4'd8;
  localparam logic [3:0] S_CPWR  = 4'd9;
  localparam logic [3:0] S_RTEST = 4'd10;
  localparam logic [3:0] S_RHASH = 4'd11;
  localparam logic [3:0] S_RFREE = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [3:0]        state;
  logic [1:0]        act;
  logic [VAL_W-1:0]  nv;
  logic [SLOT_W-1:0] i, j, dst;
  logic [CNT_W-1:0]  n;
  logic [LEN_W-1:0]  k;
  logic              hit;
  logic              mv;
  logic [TABLE_ENTRIES-1:0] used;
  logic [CNT_W-1:0]  count;
  logic [1:0]        res_status;
  logic              res_found;
  logic [VAL_W-1:0]  res_value;

  // Slot memories and their registered read data.
  logic [HASH_W-1:0] hash_mem [TABLE_ENTRIES];
  logic [LEN_W-1:0]  len_mem  [TABLE_ENTRIES];
  logic [VAL_W-1:0]  val_mem  [TABLE_ENTRIES];
  logic [7:0]        key_mem  [TABLE_ENTRIES*KEY_BYTES];
  logic [HASH_W-1:0] hash_q;
  logic [LEN_W-1:0]  len_q;
  logic [VAL_W-1:0]  val_q;
  logic [7:0]        key_q;

  logic [HASH_W-1:0] p_hash;
  logic [LEN_W-1:0]  p_len;
  logic              p_over;
  logic [7:0]        pend_q;
  logic              take;
  logic              kb_clear;

  logic                     slot_re;
  logic [SLOT_W-1:0]        slot_raddr;
  logic                     meta_we;
  logic [HASH_W-1:0]        meta_hash;
  logic [LEN_W-1:0]         meta_len;
  logic                     val_we;
  logic [VAL_W-1:0]         val_wdata;
  logic [SLOT_W+KIDX_W-1:0] key_raddr;
  logic                     key_we;
  logic [7:0]               key_wdata;
  logic [LEN_W-1:0]         cp_len;
  logic                     out_load;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);
  assign kb_clear = out_load;
  assign cp_len   = mv ? len_q : p_len;

  skht_keybuf u_keybuf (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .clear        (kb_clear),
    .rd_idx       (k[KIDX_W-1:0]),
    .hash         (p_hash),
    .len          (p_len),
    .overlong     (p_over),
    .rd_data      (pend_q)
  );

  // Memory port controls derived from the current step.
  always_comb begin
    slot_re    = ((state == S_PROBE) && !n[CNT_W-1] && used[i]) ||
                 ((state == S_RTEST) && !n[CNT_W-1] && used[j]);
    slot_raddr = (state == S_RTEST) ? j : i;
    meta_we    = 1'b0;
    val_we     = 1'b0;
    meta_hash  = p_hash;
    meta_len   = p_len;
    val_wdata  = nv;
    if ((state == S_FREE) && !used[i]) begin
      meta_we = 1'b1;
      val_we  = 1'b1;
    end
    if ((state == S_ACT) && (act == ACT_SET) && hit) begin
      val_we = 1'b1;
    end
    if ((state == S_RFREE) && !used[i] && (i != j)) begin
      meta_we   = 1'b1;
      val_we    = 1'b1;
      meta_hash = hash_q;
      meta_len  = len_q;
      val_wdata = val_q;
    end
    key_raddr = {((state == S_CRD) ? i : j), k[KIDX_W-1:0]};
    key_we    = (state == S_CPWR);
    key_wdata = mv ? key_q : pend_q;
  end

  // Slot memories: one access address per cycle, registered reads.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      hash_mem[i] <= meta_hash;
      len_mem[i]  <= meta_len;
    end
    if (val_we) begin
      val_mem[i] <= val_wdata;
    end
    if (slot_re) begin
      hash_q <= hash_mem[slot_raddr];
      len_q  <= len_mem[slot_raddr];
      val_q  <= val_mem[slot_raddr];
    end
  end

  // Stored key bytes: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[{dst, k[KIDX_W-1:0]}] <= key_wdata;
    end
    key_q <= key_mem[key_raddr];
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take && last) begin
            act   <= action;
            nv    <= new_value;
            state <= S_START;
          end
        end
        S_START: begin
          res_status <= ST_DONE;
          res_found  <= 1'b0;
          res_value  <= '0;
          mv         <= 1'b0;
          hit        <= 1'b0;
          i          <= p_hash[SLOT_W-1:0];
          n          <= '0;
          if (act == ACT_CLEAR) begin
            used  <= '0;
            count <= '0;
            state <= S_DONE;
          end else if (p_over) begin
            res_status <= ST_TOOLONG;
            state      <= S_DONE;
          end else begin
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (n[CNT_W-1] || !used[i]) begin
            hit   <= 1'b0;
            state <= S_ACT;
          end else begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          if ((hash_q == p_hash) && (len_q == p_len)) begin
            k <= '0;
            if (p_len == '0) begin
              hit   <= 1'b1;
              state <= S_ACT;
            end else begin
              state <= S_CRD;
            end
          end else begin
            i     <= i + SLOT_W'(1);
            n     <= n + CNT_W'(1);
            state <= S_PROBE;
          end
        end
        S_CRD: begin
          state <= S_CCK;
        end
        S_CCK: begin
          if (key_q == pend_q) begin
            if (k + LEN_W'(1) == p_len) begin
              hit   <= 1'b1;
              state <= S_ACT;
            end else begin
              k     <= k + LEN_W'(1);
              state <= S_CRD;
            end
          end else begin
            i     <= i + SLOT_W'(1);
            n     <= n + CNT_W'(1);
            state <= S_PROBE;
          end
        end
        S_ACT: begin
          case (act)
            ACT_GET: begin
              if (hit) begin
                res_found <= 1'b1;
                res_value <= val_q;
              end else begin
                res_status <= ST_NOTFOUND;
              end
              state <= S_DONE;
            end
            ACT_SET: begin
              if (hit) begin
                res_found <= 1'b1;
                res_value <= nv;
                state     <= S_DONE;
              end else if (count == CNT_W'(TABLE_ENTRIES)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                i     <= p_hash[SLOT_W-1:0];
                state <= S_FREE;
              end
            end
            default: begin
              if (hit) begin
                res_found <= 1'b1;
                used[i]   <= 1'b0;
                count     <= count - CNT_W'(1);
                j         <= i + SLOT_W'(1);
                n         <= CNT_W'(1);
                state     <= S_RTEST;
              end else begin
                res_status <= ST_NOTFOUND;
                state      <= S_DONE;
              end
            end
          endcase
        end
        S_FREE: begin
          if (!used[i]) begin
            used[i]   <= 1'b1;
            count     <= count + CNT_W'(1);
            res_value <= nv;
            dst       <= i;
            k         <= '0;
            state     <= (p_len == '0) ? S_DONE : S_CPRD;
          end else begin
            i <= i + SLOT_W'(1);
          end
        end
        S_CPRD: begin
          state <= S_CPWR;
        end
        S_CPWR: begin
          if (k + LEN_W'(1) == cp_len) begin
            if (mv) begin
              j     <= j + SLOT_W'(1);
              n     <= n + CNT_W'(1);
              state <= S_RTEST;
            end else begin
              state <= S_DONE;
            end
          end else begin
            k     <= k + LEN_W'(1);
            state <= S_CPRD;
          end
        end
        S_RTEST: begin
          if (n[CNT_W-1] || !used[j]) begin
            state <= S_DONE;
          end else begin
            state <= S_RHASH;
          end
        end
        S_RHASH: begin
          i     <= hash_q[SLOT_W-1:0];
          state <= S_RFREE;
        end
        S_RFREE: begin
          // The entry under test counts as free while its new place is searched.
          if (i == j) begin
            j     <= j + SLOT_W'(1);
            n     <= n + CNT_W'(1);
            state <= S_RTEST;
          end else if (!used[i]) begin
            used[i] <= 1'b1;
            used[j] <= 1'b0;
            dst     <= i;
            mv      <= 1'b1;
            k       <= '0;
            if (len_q == '0) begin
              j     <= j + SLOT_W'(1);
              n     <= n + CNT_W'(1);
              state <= S_RTEST;
            end else begin
              state <= S_CPRD;
            end
          end else begin
            i <= i + SLOT_W'(1);
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: holds one result until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= res_status;
      found       <= res_found;
      read_value  <= res_value;
      entry_count <= count;
    end
  end

endmodule

/* tb/sv/string_key_hash_table_test.sv */
// Self-checking testbench for the string key hash table with a built-in table model.
`timescale 1ns / 100ps

module string_key_hash_table_test;
  import skht_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_GET;
  logic [7:0] key_byte = 8'd0;
  logic byte_present = 1'b0;
  logic last = 1'b0;
  logic signed [31:0] new_value = 32'sd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic found;
  logic signed [31:0] read_value;
  logic [8:0] entry_count;

  string_key_hash_table dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key_byte(key_byte), .byte_present(byte_present),
    .last(last), .new_value(new_value), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found(found),
    .read_value(read_value), .entry_count(entry_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] status;
    logic found;
    logic [31:0] value;
    logic [8:0] count;
  } answer_t;

  typedef struct {
    logic [1:0] act;
    logic [7:0] kb;
    logic pres;
    logic lst;
    logic [31:0] nv;
    logic chk;
    answer_t ans;
  } request_row_t;

  // Shadow copy of the table.
  logic mdl_used [TABLE_ENTRIES];
  logic [63:0] mdl_hash [TABLE_ENTRIES];
  logic [7:0] mdl_key [TABLE_ENTRIES][KEY_BYTES];
  logic [6:0] mdl_len [TABLE_ENTRIES];
  logic [31:0] mdl_val [TABLE_ENTRIES];
  int mdl_count;
  logic [7:0] acc_key [KEY_BYTES];
  logic [63:0] acc_hash;
  int acc_len;
  logic acc_over;

  answer_t pending_answers[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  localparam int WATCHDOG = 500000;

  // Key pool kept small so that repeats, collisions and removes occur often.
  logic [7:0] pool_bytes [24][KEY_BYTES + 2];
  int pool_len [24];

  function automatic void table_reset();
    for (int i = 0; i < TABLE_ENTRIES; i++) mdl_used[i] = 1'b0;
    mdl_count = 0;
    acc_hash = 64'd0;
    acc_len = 0;
    acc_over = 1'b0;
  endfunction

  function automatic int find_key();
    int i;
    bit same;
    i = int'(acc_hash % TABLE_ENTRIES);
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (!mdl_used[i]) return -1;
      if (mdl_hash[i] == acc_hash && mdl_len[i] == acc_len) begin
        same = 1'b1;
        for (int b = 0; b < acc_len; b++) if (mdl_key[i][b] != acc_key[b]) same = 1'b0;
        if (same) return i;
      end
      i = (i + 1) % TABLE_ENTRIES;
    end
    return -1;
  endfunction

  function automatic int first_free(logic [63:0] h);
    int i;
    i = int'(h % TABLE_ENTRIES);
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (!mdl_used[i]) return i;
      i = (i + 1) % TABLE_ENTRIES;
    end
    return -1;
  endfunction

  // Delete an entry and reinsert the rest of its cluster.
  function automatic void delete_entry(int hole);
    int j;
    int dst;
    j = (hole + 1) % TABLE_ENTRIES;
    mdl_used[hole] = 1'b0;
    mdl_count--;
    for (int n = 1; n < TABLE_ENTRIES && mdl_used[j]; n++) begin
      mdl_used[j] = 1'b0;
      dst = first_free(mdl_hash[j]);
      if (dst >= 0 && dst != j) begin
        mdl_hash[dst] = mdl_hash[j];
        mdl_len[dst] = mdl_len[j];
        mdl_val[dst] = mdl_val[j];
        for (int b = 0; b < KEY_BYTES; b++) mdl_key[dst][b] = mdl_key[j][b];
        mdl_used[dst] = 1'b1;
      end else begin
        mdl_used[j] = 1'b1;
      end
      j = (j + 1) % TABLE_ENTRIES;
    end
  endfunction

  // Advance the model by one request item; returns 1 when a result is due.
  function automatic bit table_step(request_row_t r, output answer_t a);
    int at;
    int dst;
    a = '0;
    if (r.pres && r.kb != 8'd0) begin
      if (acc_len >= KEY_BYTES) acc_over = 1'b1;
      else begin
        acc_key[acc_len] = r.kb;
        acc_len++;
        acc_hash = acc_hash * 64'd131 + 64'(r.kb);
      end
    end
    if (!r.lst) return 1'b0;
    if (r.act == ACT_CLEAR) begin
      table_reset();
    end else if (acc_over) begin
      a.status = ST_TOOLONG;
    end else begin
      at = find_key();
      case (r.act)
        ACT_GET: begin
          if (at >= 0) begin
            a.found = 1'b1;
            a.value = mdl_val[at];
          end else a.status = ST_NOTFOUND;
        end
        ACT_SET: begin
          if (at >= 0) begin
            a.found = 1'b1;
            mdl_val[at] = r.nv;
            a.value = r.nv;
          end else begin
            dst = (mdl_count < TABLE_ENTRIES) ? first_free(acc_hash) : -1;
            if (dst < 0) a.status = ST_FULL;
            else begin
              mdl_hash[dst] = acc_hash;
              mdl_len[dst] = 7'(acc_len);
              mdl_val[dst] = r.nv;
              for (int b = 0; b < KEY_BYTES; b++)
                mdl_key[dst][b] = (b < acc_len) ? acc_key[b] : 8'd0;
              mdl_used[dst] = 1'b1;
              mdl_count++;
              a.value = r.nv;
            end
          end
        end
        default: begin
          if (at >= 0) begin
            a.found = 1'b1;
            delete_entry(at);
          end else a.status = ST_NOTFOUND;
        end
      endcase
    end
    acc_hash = 64'd0;
    acc_len = 0;
    acc_over = 1'b0;
    a.count = 9'(mdl_count);
    return 1'b1;
  endfunction

  // Present one item after a random gap if randomize_gap is set and wait for it to be taken.
  task automatic send_item(request_row_t r, bit randomize_gap);
    answer_t a;
    int gap;
    gap = randomize_gap ? $urandom_range(8) : 0;
    if (randomize_gap && $urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.act;
    key_byte <= r.kb;
    byte_present <= r.pres;
    last <= r.lst;
    new_value <= r.nv;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (table_step(r, a)) begin
      if (r.chk && a != r.ans) begin
        $error("directed row: expected answer %h, model gives %h", r.ans, a);
        errors++;
      end
      pending_answers.push_back(a);
    end
  endtask

  // Send a whole key as a request, empty keys as a single item.
  task automatic send_key(logic [1:0] act, int key_id, logic [31:0] nv, bit noise);
    request_row_t r;
    int n;
    n = pool_len[key_id];
    r.chk = 1'b0;
    r.ans = '0;
    if (n == 0) begin
      r.act = act; r.kb = 8'($urandom); r.pres = 1'b0; r.lst = 1'b1; r.nv = nv;
      send_item(r, 1'b1);
      return;
    end
    for (int b = 0; b < n; b++) begin
      r.act = (b == n - 1) ? act : 2'($urandom);
      r.kb = pool_bytes[key_id][b];
      r.pres = 1'b1;
      r.lst = (b == n - 1);
      r.nv = (b == n - 1) ? nv : $urandom;
      if (noise && $urandom_range(15) == 0) begin
        request_row_t z;
        z = r;
        z.lst = 1'b0;
        z.pres = 1'($urandom_range(1));
        z.kb = z.pres ? 8'd0 : 8'($urandom);
        send_item(z, 1'b1);
      end
      send_item(r, 1'b1);
    end
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Random stall on the result side, redrawn after every accepted result.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      stall_left = $urandom_range(8);
      if ($urandom_range(3) == 0) stall_left = 0;
      out_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, status); errors++;
        end
        if (found !== e.found) begin
          $error("found: expected %0d, actual %0d", e.found, found); errors++;
        end
        if (read_value !== e.value) begin
          $error("read_value: expected %0d, actual %0d", $signed(e.value), read_value);
          errors++;
        end
        if (entry_count !== e.count) begin
          $error("entry_count: expected %0d, actual %0d", e.count, entry_count); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else if (!rst) idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  request_row_t directed [$];

  function automatic request_row_t row(logic [1:0] act, logic [7:0] kb, logic pres,
                                       logic lst, logic [31:0] nv, logic chk,
                                       answer_t ans);
    request_row_t r;
    r.act = act; r.kb = kb; r.pres = pres; r.lst = lst; r.nv = nv;
    r.chk = chk; r.ans = ans;
    return r;
  endfunction

  initial begin
    int pick;
    int act_draw;
    table_reset();
    for (int k = 0; k < 24; k++) begin
      pool_len[k] = (k == 0) ? 0 : (k < 20) ? $urandom_range(1, 4) : $urandom_range(5, 12);
      for (int b = 0; b < KEY_BYTES + 2; b++) pool_bytes[k][b] = 8'($urandom_range(1, 255));
    end
    pool_len[1] = 1;
    pool_bytes[1][0] = 8'hFF;
    pool_len[2] = 1;
    pool_bytes[2][0] = 8'h01;

    // Directed table: empty table, extremes, all actions, zero bytes.
    directed.push_back(row(ACT_GET, 8'h00, 1'b0, 1'b1, 32'd0, 1'b1, {ST_NOTFOUND, 1'b0, 32'd0, 9'd0}));
    directed.push_back(row(ACT_REMOVE, 8'h5A, 1'b0, 1'b1, 32'd0, 1'b1, {ST_NOTFOUND, 1'b0, 32'd0, 9'd0}));
    directed.push_back(row(ACT_SET, 8'hFF, 1'b1, 1'b1, 32'h7FFFFFFF, 1'b1, {ST_DONE, 1'b0, 32'h7FFFFFFF, 9'd1}));
    directed.push_back(row(ACT_SET, 8'h00, 1'b0, 1'b1, 32'h80000000, 1'b1, {ST_DONE, 1'b0, 32'h80000000, 9'd2}));
    directed.push_back(row(ACT_GET, 8'hFF, 1'b1, 1'b1, 32'd0, 1'b1, {ST_DONE, 1'b1, 32'h7FFFFFFF, 9'd2}));
    directed.push_back(row(ACT_SET, 8'h00, 1'b1, 1'b1, 32'hFFFFFFFF, 1'b1, {ST_DONE, 1'b1, 32'hFFFFFFFF, 9'd2}));
    directed.push_back(row(ACT_CLEAR, 8'h41, 1'b1, 1'b0, 32'h12345678, 1'b0, '0));
    directed.push_back(row(ACT_SET, 8'h42, 1'b1, 1'b1, 32'h00000001, 1'b0, '0));
    directed.push_back(row(ACT_GET, 8'h41, 1'b1, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(row(ACT_GET, 8'h00, 1'b1, 1'b0, 32'd0, 1'b0, '0));
    directed.push_back(row(ACT_GET, 8'h42, 1'b1, 1'b1, 32'd0, 1'b0, '0));
    directed.push_back(row(ACT_REMOVE, 8'hFF, 1'b1, 1'b1, 32'd7, 1'b1, {ST_DONE, 1'b1, 32'd0, 9'd2}));
    directed.push_back(row(ACT_GET, 8'hFF, 1'b1, 1'b1, 32'd0, 1'b1, {ST_NOTFOUND, 1'b0, 32'd0, 9'd2}));
    directed.push_back(row(ACT_CLEAR, 8'hAA, 1'b1, 1'b1, 32'd0, 1'b1, {ST_DONE, 1'b0, 32'd0, 9'd0}));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_item(directed[i], 1'b1);

    // Overlong key for get, then for clear, which ignores it.
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b <= KEY_BYTES; b++)
        send_item(row(a ? ACT_CLEAR : ACT_GET, 8'($urandom_range(1, 255)), 1'b1,
                      b == KEY_BYTES, 32'd0, 1'b1,
                      a ? answer_t'({ST_DONE, 1'b0, 32'd0, 9'd0})
                        : answer_t'({ST_TOOLONG, 1'b0, 32'd0, 9'd0})), 1'b0);
    end
    hold_until_drained();

    // Random requests over a small key pool.
    while (items_sent < 750) begin
      pick = $urandom_range(23);
      act_draw = $urandom_range(99);
      if (act_draw < 2) send_key(ACT_CLEAR, pick, $urandom, 1'b1);
      else if (act_draw < 40) send_key(ACT_SET, pick, $urandom, 1'b1);
      else if (act_draw < 70) send_key(ACT_GET, pick, $urandom, 1'b1);
      else send_key(ACT_REMOVE, pick, $urandom, 1'b1);
      if (items_sent > 400 && items_sent < 420) hold_until_drained();
    end

    // Fill the table beyond capacity with fresh keys, then probe it with gets and removes.
    for (int k = 0; k < TABLE_ENTRIES + 4; k++) begin
      pool_len[23] = 2;
      pool_bytes[23][0] = 8'(k % 255 + 1);
      pool_bytes[23][1] = 8'(k / 255 + 1);
      send_key(ACT_SET, 23, $urandom, 1'b0);
    end
    for (int k = 0; k < 40; k++) begin
      pool_len[23] = 2;
      pool_bytes[23][0] = 8'($urandom_range(1, 255));
      pool_bytes[23][1] = 8'($urandom_range(1, 2));
      send_key($urandom_range(1) ? ACT_REMOVE : ACT_GET, 23, $urandom, 1'b0);
    end

    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("Sent %0d items; checked %0d results over get, set, remove, clear,",
             items_sent, results_seen);
    $display("overlong keys, empty keys, a full table and random stalls on both sides.");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
